>>> rtl/snfc_pkg.sv
// Shared types and constants of the SPI NOR flash command sequencer.
// Used by the front end, the job queue, the back end and the top level.
package snfc_pkg;

   localparam int ADDR_W = 24;
   localparam int DEF_PAGE_BYTES = 256;
   localparam int DEF_SECTOR_BYTES = 4096;
   localparam logic [15:0] POLL_LIMIT_RESET = 16'd500;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   // Request opcodes.
   localparam logic [1:0] OP_READ = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_ERASE = 2'd2;
   localparam logic [1:0] OP_STATUS = 2'd3;

   // Completion codes.
   localparam logic [2:0] ST_NONE = 3'd0;
   localparam logic [2:0] ST_DONE = 3'd1;
   localparam logic [2:0] ST_TIMEOUT = 3'd2;
   localparam logic [2:0] ST_MISALIGN = 3'd3;
   localparam logic [2:0] ST_SEQUENCE = 3'd4;

   // Flash commands.
   localparam logic [7:0] CMD_WREN = 8'h06;
   localparam logic [7:0] CMD_READ = 8'h03;
   localparam logic [7:0] CMD_PROGRAM = 8'h02;
   localparam logic [7:0] CMD_ERASE = 8'h20;
   localparam logic [7:0] CMD_RDSR = 8'h05;
   localparam logic [7:0] DUMMY_BYTE = 8'hFF;

   // A job is a set of slots of one canonical word sequence, sent lowest slot first.
   localparam int NUM_SLOTS = 9;
   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam logic [SLOT_W-1:0] SLOT_WREN = SLOT_W'(0);
   localparam logic [SLOT_W-1:0] SLOT_CMD = SLOT_W'(1);
   localparam logic [SLOT_W-1:0] SLOT_ADDR_HI = SLOT_W'(2);
   localparam logic [SLOT_W-1:0] SLOT_ADDR_MID = SLOT_W'(3);
   localparam logic [SLOT_W-1:0] SLOT_ADDR_LO = SLOT_W'(4);
   localparam logic [SLOT_W-1:0] SLOT_DATA = SLOT_W'(5);
   localparam logic [SLOT_W-1:0] SLOT_POLL_CMD = SLOT_W'(6);
   localparam logic [SLOT_W-1:0] SLOT_POLL_RD = SLOT_W'(7);
   localparam logic [SLOT_W-1:0] SLOT_REPORT = SLOT_W'(8);

   localparam logic [NUM_SLOTS-1:0] MASK_WREN = NUM_SLOTS'(1) << SLOT_WREN;
   localparam logic [NUM_SLOTS-1:0] MASK_HEADER = (NUM_SLOTS'(1) << SLOT_CMD)
      | (NUM_SLOTS'(1) << SLOT_ADDR_HI) | (NUM_SLOTS'(1) << SLOT_ADDR_MID)
      | (NUM_SLOTS'(1) << SLOT_ADDR_LO);
   localparam logic [NUM_SLOTS-1:0] MASK_DATA = NUM_SLOTS'(1) << SLOT_DATA;
   localparam logic [NUM_SLOTS-1:0] MASK_POLL = (NUM_SLOTS'(1) << SLOT_POLL_CMD)
      | (NUM_SLOTS'(1) << SLOT_POLL_RD);
   localparam logic [NUM_SLOTS-1:0] MASK_REPORT = NUM_SLOTS'(1) << SLOT_REPORT;

   typedef struct packed {
      logic [NUM_SLOTS-1:0] mask;
      logic [7:0]           cmd;
      logic [ADDR_W-1:0]    addr;
      logic                 addr_end;
      logic [7:0]           data;
      logic                 data_end;
      logic                 data_cap;
      logic [2:0]           code;
   } job_type;

endpackage

>>> rtl/spi_nor_flash_command_sequencer.sv
// SPI NOR flash command sequencer, top level. A request makes 0 to 8 result
// words. Throughput: one result word per cycle from the output register while
// rsp_tready is high; a request is accepted each cycle while the four-entry job
// queue has room, so the back end, which sends the words of each job in turn (up
// to 8 per request), sets the sustained rate.
// Reset (synchronous, active high) returns to idle, poll limit 500, queue empty.
module spi_nor_flash_command_sequencer
   import snfc_pkg::*;
#(
   parameter int PAGE_BYTES = DEF_PAGE_BYTES,
   parameter int SECTOR_BYTES = DEF_SECTOR_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,   // poll_limit
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,     // address[23:0], data_byte[31:24], erase_length[55:32]
   input  logic [2:0]  req_tuser,     // opcode[1:0], first_item[2]
   input  logic        req_tlast,     // last_item
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,     // tx_byte[7:0], frame_end[8], capture[9],
                                      // status_code[12:10], zero[15:13]
   output logic        rsp_tuser,     // bus_valid
   output logic        rsp_tlast      // last_result
);

   logic    accept;
   logic    q_push, q_pop, q_full, q_not_empty;
   job_type q_in_job, q_out_job;

   assign req_tready = !q_full;
   assign accept = req_tvalid && req_tready;

   snfc_front #(
      .PAGE_BYTES(PAGE_BYTES),
      .SECTOR_BYTES(SECTOR_BYTES)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .accept(accept),
      .opcode(req_tuser[1:0]),
      .address(req_tdata[23:0]),
      .data_byte(req_tdata[31:24]),
      .first_item(req_tuser[2]),
      .last_item(req_tlast),
      .erase_length(req_tdata[55:32]),
      .push(q_push),
      .push_job(q_in_job)
   );

   snfc_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_job(q_in_job),
      .pop(q_pop),
      .pop_job(q_out_job),
      .full(q_full),
      .not_empty(q_not_empty)
   );

   snfc_back u_back (
      .clock(clock),
      .reset(reset),
      .job_valid(q_not_empty),
      .job_head(q_out_job),
      .job_pop(q_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("job pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_not_empty)
      else $error("job popped from an empty queue");

   a_report_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> rsp_tlast)
      else $error("completion report not marked as last word");

   a_bus_word_no_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[12:10] == ST_NONE))
      else $error("bus word carries a completion code");

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word valid right after reset");

endmodule

>>> rtl/snfc_front.sv
// Front end: holds the sequencing state and the poll limit, checks each request
// and turns it into a job descriptor. Depends on snfc_pkg.
module snfc_front
   import snfc_pkg::*;
#(
   parameter int PAGE_BYTES = DEF_PAGE_BYTES,
   parameter int SECTOR_BYTES = DEF_SECTOR_BYTES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data,
   input  logic              accept,
   input  logic [1:0]        opcode,
   input  logic [ADDR_W-1:0] address,
   input  logic [7:0]        data_byte,
   input  logic              first_item,
   input  logic              last_item,
   input  logic [ADDR_W-1:0] erase_length,
   output logic              push,
   output job_type           push_job
);

   localparam int PAGE_W = $clog2(PAGE_BYTES);
   localparam int SECT_W = $clog2(SECTOR_BYTES);
   localparam int CNT_W = ADDR_W - SECT_W;

   localparam logic [2:0] M_IDLE = 3'd0;
   localparam logic [2:0] M_READ = 3'd1;
   localparam logic [2:0] M_WRITE = 3'd2;
   localparam logic [2:0] M_WPOLL = 3'd3;
   localparam logic [2:0] M_EPOLL = 3'd4;

   logic [15:0]       poll_limit_ff;
   logic [2:0]        mode_ff, mode_in;
   logic [ADDR_W-1:0] position_ff, position_in;
   logic [CNT_W-1:0]  sectors_left_ff, sectors_left_in;
   logic [15:0]       polls_left_ff, polls_left_in;
   logic              page_open_ff, page_open_in;
   logic              write_finished_ff, write_finished_in;

   logic [15:0]       limit_m1;
   logic [ADDR_W-1:0] wr_pos, wr_next;
   logic              wr_close;
   job_type           job;

   assign limit_m1 = (poll_limit_ff == 16'd0) ? 16'd0 : poll_limit_ff - 16'd1;
   assign wr_pos = first_item ? address : position_ff;
   assign wr_next = wr_pos + ADDR_W'(1);
   assign wr_close = last_item || (wr_next[PAGE_W-1:0] == '0);

   always_comb begin
      mode_in = mode_ff;
      position_in = position_ff;
      sectors_left_in = sectors_left_ff;
      polls_left_in = polls_left_ff;
      page_open_in = page_open_ff;
      write_finished_in = write_finished_ff;
      job = '0;
      if (opcode == OP_READ && ((mode_ff == M_IDLE && first_item)
            || (mode_ff == M_READ && !first_item))) begin
         job.mask = MASK_DATA;
         job.cmd = CMD_READ;
         job.addr = address;
         job.data = DUMMY_BYTE;
         job.data_end = last_item;
         job.data_cap = 1'b1;
         job.code = ST_DONE;
         if (first_item) begin
            job.mask = job.mask | MASK_HEADER;
            mode_in = M_READ;
         end
         if (last_item) begin
            job.mask = job.mask | MASK_REPORT;
            mode_in = M_IDLE;
         end
      end else if (opcode == OP_WRITE && ((mode_ff == M_IDLE && first_item)
            || (mode_ff == M_WRITE && !first_item))) begin
         job.mask = MASK_DATA;
         job.cmd = CMD_PROGRAM;
         job.addr = wr_pos;
         job.data = data_byte;
         job.data_end = wr_close;
         mode_in = M_WRITE;
         position_in = wr_next;
         page_open_in = 1'b1;
         if (first_item || !page_open_ff) begin
            job.mask = job.mask | MASK_WREN | MASK_HEADER;
         end
         if (wr_close) begin
            job.mask = job.mask | MASK_POLL;
            page_open_in = 1'b0;
            write_finished_in = last_item;
            polls_left_in = limit_m1;
            mode_in = M_WPOLL;
         end
      end else if (opcode == OP_ERASE && mode_ff == M_IDLE) begin
         if ((|address[SECT_W-1:0]) || (|erase_length[SECT_W-1:0])) begin
            job.mask = MASK_REPORT;
            job.code = ST_MISALIGN;
         end else if (erase_length == '0) begin
            job.mask = MASK_REPORT;
            job.code = ST_DONE;
         end else begin
            job.mask = MASK_WREN | MASK_HEADER | MASK_POLL;
            job.cmd = CMD_ERASE;
            job.addr = address;
            job.addr_end = 1'b1;
            position_in = address + ADDR_W'(SECTOR_BYTES);
            sectors_left_in = erase_length[ADDR_W-1:SECT_W] - CNT_W'(1);
            polls_left_in = limit_m1;
            mode_in = M_EPOLL;
         end
      end else if (opcode == OP_STATUS && (mode_ff == M_WPOLL || mode_ff == M_EPOLL)) begin
         if (data_byte[0]) begin
            if (polls_left_ff == 16'd0) begin
               job.mask = MASK_REPORT;
               job.code = ST_TIMEOUT;
               mode_in = M_IDLE;
               page_open_in = 1'b0;
               write_finished_in = 1'b0;
               sectors_left_in = '0;
            end else begin
               job.mask = MASK_POLL;
               polls_left_in = polls_left_ff - 16'd1;
            end
         end else if (mode_ff == M_WPOLL) begin
            // A ready status between pages sends nothing; the next byte reopens a page.
            if (write_finished_ff) begin
               job.mask = MASK_REPORT;
               job.code = ST_DONE;
               write_finished_in = 1'b0;
               mode_in = M_IDLE;
            end else begin
               mode_in = M_WRITE;
            end
         end else if (sectors_left_ff == '0) begin
            job.mask = MASK_REPORT;
            job.code = ST_DONE;
            mode_in = M_IDLE;
         end else begin
            job.mask = MASK_WREN | MASK_HEADER | MASK_POLL;
            job.cmd = CMD_ERASE;
            job.addr = position_ff;
            job.addr_end = 1'b1;
            position_in = position_ff + ADDR_W'(SECTOR_BYTES);
            sectors_left_in = sectors_left_ff - CNT_W'(1);
            polls_left_in = limit_m1;
         end
      end else begin
         job.mask = MASK_REPORT;
         job.code = ST_SEQUENCE;
      end
   end

   assign push = accept && (job.mask != '0);
   assign push_job = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_limit_ff <= POLL_LIMIT_RESET;
         mode_ff <= M_IDLE;
         position_ff <= '0;
         sectors_left_ff <= '0;
         polls_left_ff <= '0;
         page_open_ff <= 1'b0;
         write_finished_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            poll_limit_ff <= csr_wr_data;
         end
         if (accept) begin
            mode_ff <= mode_in;
            position_ff <= position_in;
            sectors_left_ff <= sectors_left_in;
            polls_left_ff <= polls_left_in;
            page_open_ff <= page_open_in;
            write_finished_ff <= write_finished_in;
         end
      end
   end

endmodule

>>> rtl/snfc_queue.sv
// Short job queue between the front end and the back end.
// Depends on snfc_pkg for the job type and the depth.
module snfc_queue
   import snfc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type pop_job,
   output logic    full,
   output logic    not_empty
);

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;

   assign full = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in = count_ff + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> rtl/snfc_back.sv
// Back end: walks the slots of one job at a time and drives the result words
// from an output register. Depends on snfc_pkg.
module snfc_back
   import snfc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   input  job_type job_head,
   output logic    job_pop,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output logic [15:0] rsp_tdata,
   output logic    rsp_tuser,
   output logic    rsp_tlast
);

   job_type               cur_ff;
   logic [NUM_SLOTS-1:0]  mask_ff, mask_in;
   logic [NUM_SLOTS-1:0]  low_bit, rest;
   logic [SLOT_W-1:0]     slot;
   logic                  out_free, emit;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  bus_ff, bus_in;
   logic [7:0]            tx_ff, tx_in;
   logic                  fe_ff, fe_in;
   logic                  cap_ff, cap_in;
   logic [2:0]            code_ff, code_in;
   logic                  last_ff, last_in;

   assign low_bit = mask_ff & (~mask_ff + NUM_SLOTS'(1));
   assign rest = mask_ff & ~low_bit;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign emit = out_free && (mask_ff != '0);
   // The next job is loaded as the current one hands over its final word.
   assign job_pop = job_valid && ((mask_ff == '0) || (emit && (rest == '0)));

   always_comb begin
      slot = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            slot = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      bus_in = 1'b1;
      tx_in = 8'h00;
      fe_in = 1'b0;
      cap_in = 1'b0;
      code_in = ST_NONE;
      last_in = (rest == '0);
      case (slot)
         SLOT_WREN: begin
            tx_in = CMD_WREN;
            fe_in = 1'b1;
         end
         SLOT_CMD: tx_in = cur_ff.cmd;
         SLOT_ADDR_HI: tx_in = cur_ff.addr[23:16];
         SLOT_ADDR_MID: tx_in = cur_ff.addr[15:8];
         SLOT_ADDR_LO: begin
            tx_in = cur_ff.addr[7:0];
            fe_in = cur_ff.addr_end;
         end
         SLOT_DATA: begin
            tx_in = cur_ff.data;
            fe_in = cur_ff.data_end;
            cap_in = cur_ff.data_cap;
         end
         SLOT_POLL_CMD: tx_in = CMD_RDSR;
         SLOT_POLL_RD: begin
            tx_in = DUMMY_BYTE;
            fe_in = 1'b1;
            cap_in = 1'b1;
         end
         SLOT_REPORT: begin
            bus_in = 1'b0;
            code_in = cur_ff.code;
         end
         default: bus_in = 1'b1;
      endcase
   end

   always_comb begin
      if (job_pop) begin
         mask_in = job_head.mask;
      end else if (emit) begin
         mask_in = rest;
      end else begin
         mask_in = mask_ff;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         cur_ff <= job_head;
      end
      if (emit) begin
         bus_ff <= bus_in;
         tx_ff <= tx_in;
         fe_ff <= fe_in;
         cap_ff <= cap_in;
         code_ff <= code_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {3'b000, code_ff, cap_ff, fe_ff, tx_ff};
   assign rsp_tuser = bus_ff;
   assign rsp_tlast = last_ff;

endmodule
